// ===== hw/rtl/rplb_pkg.sv =====
// Package: constants, item types and word compression for the radix partitioner.
`default_nettype none

package rplb_pkg;

    localparam int PART_BITS        = 5;
    localparam int NUM_PARTS        = 1 << PART_BITS;
    localparam int WORDS_PER_LINE   = 8;
    localparam int WORD_W           = $clog2(WORDS_PER_LINE);
    localparam int BEAT_W           = $clog2(WORDS_PER_LINE + 1);
    localparam int LINES_PER_BUFFER = 16;
    localparam int LPB_W            = $clog2(LINES_PER_BUFFER);
    localparam int BUFFERS_PER_PART = 2;
    localparam int REGION_LINES     = LINES_PER_BUFFER * BUFFERS_PER_PART;
    localparam int LINE_W           = $clog2(REGION_LINES);
    localparam int PAYLOAD_WIDTH    = 32;
    localparam int KEY_SHIFT        = PART_BITS + PAYLOAD_WIDTH;
    localparam int MEM_DEPTH        = NUM_PARTS * WORDS_PER_LINE;
    localparam int MEM_AW           = $clog2(MEM_DEPTH);

    // Fixed field widths of the item formats
    localparam int DATA_W      = 64;
    localparam int PART_FW     = 5;
    localparam int LINE_FW     = 5;
    localparam int WORD_FW     = 3;
    localparam int COUNT_FW    = 8;
    localparam int FULL_COUNT  = LINES_PER_BUFFER * WORDS_PER_LINE;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [DATA_W-1:0]    key;
        logic [DATA_W-1:0]    row_id;
        logic [PART_FW-1:0]   flush_target;
    } in_item_t;

    typedef struct packed {
        logic [PART_FW-1:0]   part_index;
        logic [LINE_FW-1:0]   line_slot;
        logic [WORD_FW-1:0]   word_slot;
        logic [DATA_W-1:0]    word_data;
        logic                 word_valid;
        logic                 send_valid;
        logic                 send_buffer;
        logic [COUNT_FW-1:0]  send_count;
        logic                 send_rewind;
        logic                 last;
    } out_item_t;

    function automatic logic [DATA_W-1:0] compress(input logic [DATA_W-1:0] key,
                                                   input logic [DATA_W-1:0] row_id);
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] term;
        hi   = key >> PART_BITS;
        term = (KEY_SHIFT < DATA_W) ? (hi << KEY_SHIFT) : '0;
        return row_id + term;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/radix_partitioner_with_line_buffers.sv =====
// Top level: radix partitioner with per-partition line buffers in one word memory.
//
//  channel | dir | ports                    | payload
//  --------+-----+--------------------------+------------------------------
//  input   | in  | s_valid, s_ready, s_item | rplb_pkg::in_item_t
//  result  | out | m_valid, m_ready, m_item | rplb_pkg::out_item_t
//
// An insert that does not complete a line is taken with no result.
// A completed line or a flush starts a drain that issues one beat per cycle from
// the single read port of the word memory: 8 beats per line, up to 8 per flush.
// Inserts keep flowing during a drain; an item that needs a drain of its own waits
// for the running one, and an insert into the draining line waits until the drain
// has read the word it would overwrite. Result stalls hold the drain.
// aresetn clears the counters synchronously; the word memory needs no clearing.
`default_nettype none

module radix_partitioner_with_line_buffers (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire rplb_pkg::in_item_t    s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rplb_pkg::out_item_t        m_item
);

    localparam int PB = rplb_pkg::PART_BITS;
    localparam int WW = rplb_pkg::WORD_W;
    localparam int BW = rplb_pkg::BEAT_W;
    localparam int LW = rplb_pkg::LINE_W;
    localparam int CW = rplb_pkg::COUNT_FW;

    // Word memory and per-partition counters
    logic [rplb_pkg::DATA_W-1:0] line_mem [rplb_pkg::MEM_DEPTH];
    logic [WW-1:0]               fill_reg  [rplb_pkg::NUM_PARTS];
    logic [LW-1:0]               lines_reg [rplb_pkg::NUM_PARTS];

    // Drain engine
    logic                 drain_active_reg;
    logic [PB-1:0]        drain_part_reg;
    logic [LW-1:0]        drain_line_reg;
    logic [BW-1:0]        drain_idx_reg;
    logic [BW-1:0]        drain_words_reg;
    logic                 drain_extra_reg;
    logic                 drain_sendon_reg;
    logic                 drain_sbuf_reg;
    logic [CW-1:0]        drain_scount_reg;
    logic                 drain_srewind_reg;

    logic                 m_valid_reg;
    rplb_pkg::out_item_t  m_item_reg;
    logic [rplb_pkg::DATA_W-1:0] rd_data_reg;

    logic                 is_flush;
    logic [PB-1:0]        in_part;
    logic [WW-1:0]        cur_fill;
    logic [LW-1:0]        cur_lines;
    logic [LW:0]          lines_inc;
    logic                 line_full;
    logic                 full_rewind;
    logic [CW-1:0]        flush_remaining;
    logic [BW-1:0]        fill_ext;
    logic [BW-1:0]        beat_total;
    logic                 beat_last;
    logic                 beat_word;
    logic                 issue;
    logic                 drain_busy;
    logic                 wr_conflict;
    logic                 needs_drain;
    logic                 acc;
    logic [rplb_pkg::MEM_AW-1:0] wr_addr;
    logic [rplb_pkg::MEM_AW-1:0] rd_addr;
    rplb_pkg::out_item_t  beat;

    always_comb begin
        is_flush        = (s_item.kind == rplb_pkg::KIND_FLUSH);
        in_part         = is_flush ? s_item.flush_target[PB-1:0] : s_item.key[PB-1:0];
        cur_fill        = fill_reg[in_part];
        cur_lines       = lines_reg[in_part];
        lines_inc       = {1'b0, cur_lines} + (LW+1)'(1);
        line_full       = (cur_fill == WW'(rplb_pkg::WORDS_PER_LINE - 1));
        full_rewind     = (lines_inc == (LW+1)'(rplb_pkg::REGION_LINES));
        flush_remaining = CW'(cur_lines[rplb_pkg::LPB_W-1:0]) * CW'(rplb_pkg::WORDS_PER_LINE)
                          + CW'(cur_fill);
        fill_ext        = BW'(cur_fill);

        beat_total = drain_words_reg + BW'(drain_extra_reg);
        beat_last  = (drain_idx_reg == beat_total - BW'(1));
        beat_word  = (drain_idx_reg < drain_words_reg);
        issue      = drain_active_reg && (!m_valid_reg || m_ready);
        drain_busy = drain_active_reg && !(issue && beat_last);

        // Hold an insert that would overwrite a word the drain has not read yet
        wr_conflict = !is_flush && drain_active_reg && (in_part == drain_part_reg)
                      && (fill_ext < drain_words_reg)
                      && ((fill_ext > drain_idx_reg)
                          || ((fill_ext == drain_idx_reg) && !issue));
        needs_drain = is_flush || line_full;
        s_ready     = !(needs_drain && drain_busy) && !wr_conflict;
        acc         = s_valid && s_ready;

        wr_addr = {in_part, cur_fill};
        rd_addr = {drain_part_reg, drain_idx_reg[WW-1:0]};

        beat             = '0;
        beat.part_index  = rplb_pkg::PART_FW'(drain_part_reg);
        beat.last        = beat_last;
        if (beat_word) begin
            beat.word_valid = 1'b1;
            beat.line_slot  = rplb_pkg::LINE_FW'(drain_line_reg);
            beat.word_slot  = rplb_pkg::WORD_FW'(drain_idx_reg);
        end
        if ((beat_word && drain_sendon_reg && beat_last) || !beat_word) begin
            beat.send_valid  = 1'b1;
            beat.send_buffer = drain_sbuf_reg;
            beat.send_count  = drain_scount_reg;
            beat.send_rewind = drain_srewind_reg;
        end
    end

    // Memory write on insert; registered read data sits beside the output register
    always_ff @(posedge aclk) begin
        if (acc && !is_flush) begin
            line_mem[wr_addr] <= rplb_pkg::compress(s_item.key, s_item.row_id);
        end
        if (issue) begin
            m_item_reg  <= beat;
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            drain_active_reg <= 1'b0;
            drain_idx_reg    <= '0;
            for (int i = 0; i < rplb_pkg::NUM_PARTS; i++) begin
                fill_reg[i]  <= '0;
                lines_reg[i] <= '0;
            end
        end else begin
            if (issue) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // A drain that starts on this edge takes over the engine
            if (issue && !(acc && needs_drain)) begin
                drain_idx_reg <= drain_idx_reg + BW'(1);
                if (beat_last) begin
                    drain_active_reg <= 1'b0;
                end
            end

            if (acc) begin
                if (is_flush) begin
                    fill_reg[in_part]  <= '0;
                    lines_reg[in_part] <= '0;
                    drain_active_reg   <= (flush_remaining != '0);
                    drain_part_reg     <= in_part;
                    drain_line_reg     <= cur_lines;
                    drain_idx_reg      <= '0;
                    drain_words_reg    <= fill_ext;
                    drain_extra_reg    <= 1'b1;
                    drain_sendon_reg   <= 1'b0;
                    drain_sbuf_reg     <= cur_lines[LW-1];
                    drain_scount_reg   <= flush_remaining;
                    drain_srewind_reg  <= 1'b0;
                end else if (line_full) begin
                    fill_reg[in_part]  <= '0;
                    lines_reg[in_part] <= full_rewind ? '0 : lines_inc[LW-1:0];
                    drain_active_reg   <= 1'b1;
                    drain_part_reg     <= in_part;
                    drain_line_reg     <= cur_lines;
                    drain_idx_reg      <= '0;
                    drain_words_reg    <= BW'(rplb_pkg::WORDS_PER_LINE);
                    drain_extra_reg    <= 1'b0;
                    drain_sendon_reg   <= (lines_inc[rplb_pkg::LPB_W-1:0] == '0);
                    drain_sbuf_reg     <= cur_lines[LW-1];
                    drain_scount_reg   <= CW'(rplb_pkg::FULL_COUNT);
                    drain_srewind_reg  <= full_rewind;
                end else begin
                    fill_reg[in_part]  <= cur_fill + WW'(1);
                end
            end
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        m_item = m_item_reg;
        // Send-only beats keep the zero data of the beat
        if (m_item_reg.word_valid) begin
            m_item.word_data = rd_data_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rplb_check.sv =====
// Checker: port-level assertions for the radix partitioner, bound to the top level.
`default_nettype none

module rplb_check (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire rplb_pkg::in_item_t   s_item,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire rplb_pkg::out_item_t  m_item
);

    // Offered input beat holds until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("input beat changed while waiting");

    // Stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    // A beat without a word is a flush send and always closes the run
    a_send_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.word_valid |-> m_item.send_valid && m_item.last)
        else $error("send-only beat malformed");

    // Full-buffer send rides on the last word of a line
    a_full_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.word_valid && m_item.send_valid |->
            m_item.last
            && (m_item.word_slot == rplb_pkg::WORD_FW'(rplb_pkg::WORDS_PER_LINE - 1))
            && (m_item.send_count == rplb_pkg::COUNT_FW'(rplb_pkg::FULL_COUNT)))
        else $error("full-buffer send on wrong beat");

    // Word fields are zero when no word is carried
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.word_valid |->
            (m_item.line_slot == '0) && (m_item.word_slot == '0) && (m_item.word_data == '0))
        else $error("word fields not cleared on send-only beat");

endmodule

bind radix_partitioner_with_line_buffers rplb_check u_rplb_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

`default_nettype wire
